// ===== rtl/mpmc_pkg.sv =====
// Shared types, constants and helpers for the multi-pattern match counter.
`default_nettype none
package mpmc_pkg;

  localparam int MAX_NODES = 4096;
  localparam int ALPHABET  = 26;
  localparam int COUNT_W   = 20;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SYM_W     = 5;
  localparam int PTR_W     = NODE_W + 1;

  typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

  typedef struct packed {
    logic             operation;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] match_count;
    logic               overflow;
  } out_t;

  typedef enum logic {
    CMD_PATTERN,
    CMD_TEXT
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e        kind;
    logic             sym_ok;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } cmd_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_PAT_RD,
    S_PAT_EX,
    S_NEW_INIT,
    S_PAT_LAST,
    S_CNT_WR,
    S_TXT_RD,
    S_TXT_EX,
    S_WALK_RD,
    S_WALK_EX,
    S_TXT_END,
    S_CLR_RD,
    S_CLR_WR,
    S_BLD_START,
    S_BLD_RDU,
    S_BLD_RDF,
    S_BLD_LDF,
    S_BLD_SYM,
    S_BLD_WR,
    S_BLD_POP
  } state_e;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/mpmc_front.sv =====
// Front end: accepts transactions, classifies them and queues them for the engine.
`default_nettype none
module mpmc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire mpmc_pkg::in_t item_i,
  output logic               cmd_valid_o,
  output mpmc_pkg::cmd_t     cmd_o,
  input  wire logic          cmd_pop_i
);

  mpmc_pkg::cmd_t fifo_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  logic           pop;
  mpmc_pkg::cmd_t cls;

  assign busy        = (cnt_q == 2'd2);
  assign push        = start & ~busy;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i & cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    cls.kind   = item_i.operation ? mpmc_pkg::CMD_TEXT : mpmc_pkg::CMD_PATTERN;
    cls.sym_ok = (item_i.symbol < mpmc_pkg::SYM_W'(mpmc_pkg::ALPHABET));
    cls.symbol = item_i.symbol;
    cls.last   = item_i.last;
  end

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("front queue count out of range");

endmodule
`default_nettype wire

// ===== rtl/mpmc_engine.sv =====
// Back end: trie insert, failure-link build, text scan and result output.
`default_nettype none
module mpmc_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_valid_i,
  input  wire mpmc_pkg::cmd_t cmd_i,
  output logic                cmd_pop_o,
  output logic                result_valid_o,
  output mpmc_pkg::out_t      result_o
);

  localparam int NW = mpmc_pkg::NODE_W;
  localparam int CW = mpmc_pkg::COUNT_W;
  localparam int PW = mpmc_pkg::PTR_W;
  localparam int SW = mpmc_pkg::SYM_W;

  // storage
  mpmc_pkg::row_t goto_mem  [mpmc_pkg::MAX_NODES];
  logic [NW-1:0]  fail_mem  [mpmc_pkg::MAX_NODES];
  logic [CW-1:0]  count_mem [mpmc_pkg::MAX_NODES];
  logic           cons_mem  [mpmc_pkg::MAX_NODES];
  logic [NW-1:0]  queue_mem [mpmc_pkg::MAX_NODES];
  logic [NW-1:0]  clist_mem [mpmc_pkg::MAX_NODES];

  mpmc_pkg::row_t goto_rd_q;
  logic [NW-1:0]  fail_rd_q, queue_rd_q, clist_rd_q;
  logic [CW-1:0]  count_rd_q;
  logic           cons_rd_q;

  logic           goto_we, fail_we, count_we, cons_we, queue_we, clist_we;
  logic [NW-1:0]  goto_wa, fail_wa, count_wa, cons_wa, queue_wa, clist_wa;
  mpmc_pkg::row_t goto_wd;
  logic [NW-1:0]  fail_wd, queue_wd, clist_wd;
  logic [CW-1:0]  count_wd;
  logic           cons_wd;
  logic [NW-1:0]  goto_ra, fail_ra, count_ra, cons_ra, queue_ra, clist_ra;

  mpmc_pkg::state_e state_q, state_d;
  mpmc_pkg::cmd_t   cmd_q, cmd_d;
  logic [NW-1:0]    cur_q, cur_d;
  logic [NW-1:0]    cursor_q, cursor_d;
  logic [NW-1:0]    nodes_q, nodes_d;
  logic             text_q, text_d;
  logic             built_q, built_d;
  logic             ovf_q, ovf_d;
  logic [CW-1:0]    total_q, total_d;
  logic [NW-1:0]    walk_q, walk_d;
  logic [NW-1:0]    bld_u_q, bld_u_d;
  logic             root_q, root_d;
  mpmc_pkg::row_t   row_u_q, row_u_d;
  mpmc_pkg::row_t   row_f_q, row_f_d;
  logic [SW-1:0]    sidx_q, sidx_d;
  logic [PW-1:0]    qhead_q, qhead_d;
  logic [PW-1:0]    qtail_q, qtail_d;
  logic [PW-1:0]    ctail_q, ctail_d;
  logic [PW-1:0]    cidx_q, cidx_d;
  logic             res_valid_q, res_valid_d;
  mpmc_pkg::out_t   res_q, res_d;

  function automatic mpmc_pkg::row_t merge_row(input mpmc_pkg::row_t u,
                                               input mpmc_pkg::row_t f);
    mpmc_pkg::row_t r;
    for (int i = 0; i < mpmc_pkg::ALPHABET; i++) begin
      r[i] = (u[i] != '0) ? u[i] : f[i];
    end
    return r;
  endfunction

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  always_comb begin
    mpmc_pkg::row_t row_tmp;
    logic [NW-1:0]  nxt;
    logic [NW-1:0]  child;
    logic [NW-1:0]  fchild;

    row_tmp = goto_rd_q;
    nxt     = goto_rd_q[cmd_q.symbol];
    child   = row_u_q[sidx_q];
    fchild  = row_f_q[sidx_q];

    state_d     = state_q;
    cmd_d       = cmd_q;
    cur_d       = cur_q;
    cursor_d    = cursor_q;
    nodes_d     = nodes_q;
    text_d      = text_q;
    built_d     = built_q;
    ovf_d       = ovf_q;
    total_d     = total_q;
    walk_d      = walk_q;
    bld_u_d     = bld_u_q;
    root_d      = root_q;
    row_u_d     = row_u_q;
    row_f_d     = row_f_q;
    sidx_d      = sidx_q;
    qhead_d     = qhead_q;
    qtail_d     = qtail_q;
    ctail_d     = ctail_q;
    cidx_d      = cidx_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;

    goto_we  = 1'b0; goto_wa  = cur_q; goto_wd  = '0;
    fail_we  = 1'b0; fail_wa  = cur_q; fail_wd  = '0;
    count_we = 1'b0; count_wa = cur_q; count_wd = '0;
    cons_we  = 1'b0; cons_wa  = cur_q; cons_wd  = 1'b0;
    queue_we = 1'b0; queue_wa = qtail_q[NW-1:0]; queue_wd = child;
    clist_we = 1'b0; clist_wa = ctail_q[NW-1:0]; clist_wd = walk_q;
    goto_ra  = cur_q;
    fail_ra  = walk_q;
    count_ra = walk_q;
    cons_ra  = walk_q;
    queue_ra = qhead_q[NW-1:0];
    clist_ra = cidx_q[NW-1:0];

    case (state_q)
      mpmc_pkg::S_INIT: begin
        // root row starts empty
        goto_we = 1'b1;
        goto_wa = '0;
        state_d = mpmc_pkg::S_IDLE;
      end
      mpmc_pkg::S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          if (cmd_i.kind == mpmc_pkg::CMD_PATTERN) begin
            if (text_q) begin
              // new dictionary: drop the old trie
              nodes_d  = '0;
              text_d   = 1'b0;
              built_d  = 1'b0;
              ovf_d    = 1'b0;
              cursor_d = '0;
              total_d  = '0;
              ctail_d  = '0;
              cur_d    = '0;
              goto_we  = 1'b1;
              goto_wa  = '0;
              state_d  = mpmc_pkg::S_PAT_RD;
            end else if (!ovf_q) begin
              cur_d   = cursor_q;
              state_d = mpmc_pkg::S_PAT_RD;
            end
          end else begin
            if (!text_q) begin
              text_d  = 1'b1;
              cur_d   = '0;
              total_d = '0;
              state_d = built_q ? mpmc_pkg::S_TXT_RD : mpmc_pkg::S_BLD_START;
            end else begin
              cur_d   = cursor_q;
              state_d = mpmc_pkg::S_TXT_RD;
            end
          end
        end
      end
      mpmc_pkg::S_PAT_RD: begin
        state_d = cmd_q.sym_ok ? mpmc_pkg::S_PAT_EX : mpmc_pkg::S_PAT_LAST;
      end
      mpmc_pkg::S_PAT_EX: begin
        if (nxt == '0) begin
          if (nodes_q != NW'(mpmc_pkg::MAX_NODES - 1)) begin
            row_tmp[cmd_q.symbol] = nodes_q + 1'b1;
            goto_we = 1'b1;
            goto_wd = row_tmp;
            nodes_d = nodes_q + 1'b1;
            cur_d   = nodes_q + 1'b1;
            state_d = mpmc_pkg::S_NEW_INIT;
          end else begin
            ovf_d    = 1'b1;
            cursor_d = '0;
            state_d  = mpmc_pkg::S_IDLE;
          end
        end else begin
          cur_d   = nxt;
          state_d = mpmc_pkg::S_PAT_LAST;
        end
      end
      mpmc_pkg::S_NEW_INIT: begin
        goto_we  = 1'b1;
        fail_we  = 1'b1;
        count_we = 1'b1;
        cons_we  = 1'b1;
        state_d  = mpmc_pkg::S_PAT_LAST;
      end
      mpmc_pkg::S_PAT_LAST: begin
        count_ra = cur_q;
        if (cmd_q.last && cur_q != '0) begin
          state_d = mpmc_pkg::S_CNT_WR;
        end else begin
          cursor_d = cmd_q.last ? '0 : cur_q;
          state_d  = mpmc_pkg::S_IDLE;
        end
      end
      mpmc_pkg::S_CNT_WR: begin
        count_we = 1'b1;
        count_wd = mpmc_pkg::sat_add(count_rd_q, CW'(1));
        cursor_d = '0;
        state_d  = mpmc_pkg::S_IDLE;
      end
      mpmc_pkg::S_TXT_RD: begin
        if (cmd_q.sym_ok) begin
          state_d = mpmc_pkg::S_TXT_EX;
        end else begin
          cur_d   = '0;
          walk_d  = '0;
          state_d = mpmc_pkg::S_WALK_RD;
        end
      end
      mpmc_pkg::S_TXT_EX: begin
        cur_d   = nxt;
        walk_d  = nxt;
        state_d = mpmc_pkg::S_WALK_RD;
      end
      mpmc_pkg::S_WALK_RD: begin
        state_d = (walk_q == '0) ? mpmc_pkg::S_TXT_END : mpmc_pkg::S_WALK_EX;
      end
      mpmc_pkg::S_WALK_EX: begin
        if (cons_rd_q) begin
          state_d = mpmc_pkg::S_TXT_END;
        end else begin
          total_d  = mpmc_pkg::sat_add(total_q, count_rd_q);
          cons_we  = 1'b1;
          cons_wa  = walk_q;
          cons_wd  = 1'b1;
          clist_we = 1'b1;
          ctail_d  = ctail_q + 1'b1;
          walk_d   = fail_rd_q;
          state_d  = mpmc_pkg::S_WALK_RD;
        end
      end
      mpmc_pkg::S_TXT_END: begin
        if (cmd_q.last) begin
          res_valid_d       = 1'b1;
          res_d.match_count = total_q;
          res_d.overflow    = ovf_q;
          total_d           = '0;
          cursor_d          = '0;
          cidx_d            = '0;
          state_d           = mpmc_pkg::S_CLR_RD;
        end else begin
          cursor_d = cur_q;
          state_d  = mpmc_pkg::S_IDLE;
        end
      end
      mpmc_pkg::S_CLR_RD: begin
        // unmark every node consumed by this text
        if (cidx_q == ctail_q) begin
          ctail_d = '0;
          state_d = mpmc_pkg::S_IDLE;
        end else begin
          state_d = mpmc_pkg::S_CLR_WR;
        end
      end
      mpmc_pkg::S_CLR_WR: begin
        cons_we = 1'b1;
        cons_wa = clist_rd_q;
        cons_wd = 1'b0;
        cidx_d  = cidx_q + 1'b1;
        state_d = mpmc_pkg::S_CLR_RD;
      end
      mpmc_pkg::S_BLD_START: begin
        qhead_d = '0;
        qtail_d = '0;
        bld_u_d = '0;
        root_d  = 1'b1;
        state_d = mpmc_pkg::S_BLD_RDU;
      end
      mpmc_pkg::S_BLD_RDU: begin
        goto_ra = bld_u_q;
        fail_ra = bld_u_q;
        state_d = mpmc_pkg::S_BLD_RDF;
      end
      mpmc_pkg::S_BLD_RDF: begin
        row_u_d = goto_rd_q;
        goto_ra = fail_rd_q;
        state_d = mpmc_pkg::S_BLD_LDF;
      end
      mpmc_pkg::S_BLD_LDF: begin
        // root children fail to the root
        row_f_d = root_q ? '0 : goto_rd_q;
        sidx_d  = '0;
        state_d = mpmc_pkg::S_BLD_SYM;
      end
      mpmc_pkg::S_BLD_SYM: begin
        if (child != '0) begin
          fail_we = 1'b1;
          fail_wa = child;
          fail_wd = fchild;
          if (qtail_q < PW'(mpmc_pkg::MAX_NODES)) begin
            queue_we = 1'b1;
            qtail_d  = qtail_q + 1'b1;
          end
        end
        if (sidx_q == SW'(mpmc_pkg::ALPHABET - 1)) begin
          state_d = mpmc_pkg::S_BLD_WR;
        end else begin
          sidx_d = sidx_q + 1'b1;
        end
      end
      mpmc_pkg::S_BLD_WR: begin
        goto_we = 1'b1;
        goto_wa = bld_u_q;
        goto_wd = merge_row(row_u_q, row_f_q);
        if (qhead_q == qtail_q) begin
          built_d = 1'b1;
          state_d = mpmc_pkg::S_TXT_RD;
        end else begin
          qhead_d = qhead_q + 1'b1;
          state_d = mpmc_pkg::S_BLD_POP;
        end
      end
      mpmc_pkg::S_BLD_POP: begin
        bld_u_d = queue_rd_q;
        root_d  = 1'b0;
        state_d = mpmc_pkg::S_BLD_RDU;
      end
      default: begin
        state_d = mpmc_pkg::S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mpmc_pkg::S_INIT;
      cursor_q    <= '0;
      nodes_q     <= '0;
      text_q      <= 1'b0;
      built_q     <= 1'b0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      qhead_q     <= '0;
      qtail_q     <= '0;
      ctail_q     <= '0;
      cidx_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cursor_q    <= cursor_d;
      nodes_q     <= nodes_d;
      text_q      <= text_d;
      built_q     <= built_d;
      ovf_q       <= ovf_d;
      total_q     <= total_d;
      qhead_q     <= qhead_d;
      qtail_q     <= qtail_d;
      ctail_q     <= ctail_d;
      cidx_q      <= cidx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    cur_q   <= cur_d;
    walk_q  <= walk_d;
    bld_u_q <= bld_u_d;
    root_q  <= root_d;
    row_u_q <= row_u_d;
    row_f_q <= row_f_d;
    sidx_q  <= sidx_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    goto_rd_q <= goto_mem[goto_ra];
  end

  always_ff @(posedge clk_i) begin
    if (fail_we) fail_mem[fail_wa] <= fail_wd;
    fail_rd_q <= fail_mem[fail_ra];
  end

  always_ff @(posedge clk_i) begin
    if (count_we) count_mem[count_wa] <= count_wd;
    count_rd_q <= count_mem[count_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cons_we) cons_mem[cons_wa] <= cons_wd;
    cons_rd_q <= cons_mem[cons_ra];
  end

  always_ff @(posedge clk_i) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd_q <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk_i) begin
    if (clist_we) clist_mem[clist_wa] <= clist_wd;
    clist_rd_q <= clist_mem[clist_ra];
  end

  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |=> !res_valid_q) else $error("result strobe longer than one cycle");

  a_walk_nonroot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpmc_pkg::S_WALK_EX |-> walk_q != '0) else $error("walk reached root");

  a_bld_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == mpmc_pkg::S_BLD_SYM |-> sidx_q < SW'(mpmc_pkg::ALPHABET))
    else $error("build symbol index out of range");

endmodule
`default_nettype wire

// ===== rtl/multi_pattern_match_counter.sv =====
// Steps: a pattern symbol reads and extends the trie (ignored after overflow); a text symbol
// moves the cursor (to the root when out of range), then walks the fail links over newly
// consumed nodes up to the root or a consumed node. Last text symbol: result strobe, then each
// consumed node is unmarked. First text symbol after loading builds fail links, root included.
// One transaction at a time in the engine; a 2-entry queue decouples the front. No result stall.
// Reset: asynchronous, active low; after release the engine clears the root row, then goes idle.
`default_nettype none
module multi_pattern_match_counter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire mpmc_pkg::in_t item_i,
  output logic               result_valid_o,
  output mpmc_pkg::out_t     result_o
);

  logic           cmd_valid;
  logic           cmd_pop;
  mpmc_pkg::cmd_t cmd;

  mpmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mpmc_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .cmd_pop_o      (cmd_pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for the match counter: directed and random dictionaries and texts against a predictor.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpmc_pkg::*;

  localparam int NN = MAX_NODES;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t item_i = '0;
  logic result_valid_o;
  out_t result_o;

  multi_pattern_match_counter dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .result_valid_o(result_valid_o), .result_o(result_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [NODE_W-1:0] trie_next [NN*ALPHABET];
  logic [NODE_W-1:0] fail_of [NN];
  logic [COUNT_W-1:0] end_count [NN];
  bit visited [NN];
  logic [NODE_W-1:0] bfs_q [NN];
  int unsigned node_total;
  logic [NODE_W-1:0] cur_node;
  logic [COUNT_W-1:0] found_total;
  bit scanning, links_done, trie_full;

  out_t counts_due[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  bit calm = 1'b0;

  function automatic logic [COUNT_W-1:0] add_sat(logic [COUNT_W-1:0] a, logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? '1 : s[COUNT_W-1:0];
  endfunction

  function automatic void wipe_dictionary();
    foreach (trie_next[i]) trie_next[i] = '0;
    foreach (fail_of[i]) begin
      fail_of[i] = '0;
      end_count[i] = '0;
      visited[i] = 1'b0;
    end
    node_total = 0;
    cur_node = '0;
    found_total = '0;
    scanning = 0;
    links_done = 0;
    trie_full = 0;
  endfunction

  function automatic void build_fail_links();
    int head, tail;
    int u, f, c, fc;
    head = 0;
    tail = 0;
    for (int i = 0; i < ALPHABET; i++)
      if (trie_next[i] != 0 && tail < NN) bfs_q[tail++] = trie_next[i];
    while (head < tail) begin
      u = bfs_q[head++];
      f = fail_of[u];
      for (int i = 0; i < ALPHABET; i++) begin
        c = trie_next[u*ALPHABET+i];
        fc = trie_next[f*ALPHABET+i];
        if (c != 0) begin
          fail_of[c] = fc;
          if (tail < NN) bfs_q[tail++] = c;
        end else begin
          trie_next[u*ALPHABET+i] = fc;
        end
      end
    end
    links_done = 1;
  endfunction

  function automatic void predict_item(in_t it);
    int cur, nxt, j;
    out_t r;
    cur = cur_node;
    if (it.operation == CMD_PATTERN) begin
      if (scanning) wipe_dictionary();
      if (trie_full) return;
      cur = cur_node;
      if (it.symbol < ALPHABET) begin
        nxt = trie_next[cur*ALPHABET+it.symbol];
        if (nxt == 0) begin
          if (node_total < NN-1) begin
            node_total++;
            nxt = node_total;
            trie_next[cur*ALPHABET+it.symbol] = nxt;
          end else begin
            trie_full = 1;
            cur_node = '0;
            return;
          end
        end
        cur = nxt;
      end
      if (it.last) begin
        end_count[cur] = add_sat(end_count[cur], 1);
        cur = 0;
      end
      cur_node = cur;
      return;
    end
    if (!scanning) begin
      scanning = 1;
      cur = 0;
      found_total = '0;
      if (!links_done) build_fail_links();
    end
    cur = (it.symbol < ALPHABET) ? trie_next[cur*ALPHABET+it.symbol] : 0;
    j = cur;
    while (j != 0 && !visited[j]) begin
      found_total = add_sat(found_total, end_count[j]);
      visited[j] = 1;
      j = fail_of[j];
    end
    cur_node = cur;
    if (!it.last) return;
    r.match_count = found_total;
    r.overflow = trie_full;
    counts_due.push_back(r);
    found_total = '0;
    cur_node = '0;
    foreach (visited[i]) visited[i] = 1'b0;
  endfunction

  task automatic send_item(bit op, logic [SYM_W-1:0] sym, bit lst);
    in_t it;
    it.operation = op;
    it.symbol = sym;
    it.last = lst;
    while (!calm && $urandom_range(99) < 38) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_item(it);
    items_sent++;
  endtask

  task automatic send_word(bit op, int len, int alpha);
    for (int i = 0; i < len; i++)
      send_item(op, $urandom_range(alpha-1), i == len-1);
  endtask

  task automatic drain();
    int n;
    n = 0;
    start <= 1'b0;
    while (counts_due.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (50) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (result_valid_o) begin
      results_seen++;
      if (counts_due.size() == 0) begin
        $display("%0t: unexpected result count=%0d ovf=%0b", $time,
                 result_o.match_count, result_o.overflow);
        errors++;
      end else begin
        if (result_o !== counts_due[0]) begin
          $display("%0t: expected count=%0d ovf=%0b, actual count=%0d ovf=%0b", $time,
                   counts_due[0].match_count, counts_due[0].overflow,
                   result_o.match_count, result_o.overflow);
          errors++;
        end
        void'(counts_due.pop_front());
      end
    end
  end

  // extremes of symbol, out-of-range symbols, empty dictionary, unfinished pattern
  task automatic test_directed();
    send_item(CMD_TEXT, 5'd3, 1);           // empty dictionary
    send_item(CMD_PATTERN, 5'd0, 1);
    send_item(CMD_PATTERN, 5'd0, 1);        // duplicate pattern
    send_item(CMD_PATTERN, 5'd25, 0);
    send_item(CMD_PATTERN, 5'd0, 1);
    send_item(CMD_PATTERN, 5'd31, 1);       // out of range, ends on the root, no match counted
    send_item(CMD_PATTERN, 5'd1, 0);
    send_item(CMD_PATTERN, 5'd26, 0);
    send_item(CMD_PATTERN, 5'd2, 1);
    send_item(CMD_PATTERN, 5'd7, 0);        // left unfinished
    send_item(CMD_TEXT, 5'd25, 0);
    send_item(CMD_TEXT, 5'd0, 0);
    send_item(CMD_TEXT, 5'd30, 0);          // cursor back to root
    send_item(CMD_TEXT, 5'd1, 0);
    send_item(CMD_TEXT, 5'd2, 1);
    send_item(CMD_TEXT, 5'd0, 0);           // second text, same dictionary
    send_item(CMD_TEXT, 5'd0, 1);
    send_item(CMD_TEXT, 5'd31, 1);
    drain();
  endtask

  task automatic test_random();
    int np, nt, alpha;
    while (items_sent < 750) begin
      calm = (items_sent > 400 && items_sent < 520);
      alpha = ($urandom_range(3) == 0) ? 32 : $urandom_range(2, 4);
      np = $urandom_range(0, 6);
      for (int p = 0; p < np; p++) send_word(CMD_PATTERN, $urandom_range(1, 4), alpha);
      if ($urandom_range(5) == 0) send_item(CMD_PATTERN, $urandom_range(31), 0);
      nt = $urandom_range(1, 3);
      for (int t = 0; t < nt; t++) send_word(CMD_TEXT, $urandom_range(1, 12), alpha);
    end
    calm = 0;
    drain();
  endtask

  initial begin
    wipe_dictionary();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    $display("Sent %0d symbols and checked %0d match counts,", items_sent, results_seen);
    $display("covering empty, duplicate, unfinished and out-of-range patterns and repeated texts.");
    if (errors == 0 && counts_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
